### rtl/frame_timestamp_recovery_assert.svh
// Assertion macros shared by the frame timestamp recovery RTL.
`ifndef FRAME_TIMESTAMP_RECOVERY_ASSERT_SVH
`define FRAME_TIMESTAMP_RECOVERY_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define FTR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define FTR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/ftr_pkg.sv
// Shared types and constants for the frame timestamp recovery block.
package ftr_pkg;

  localparam int TIME_W         = 64;
  localparam int PERIOD_W       = 32;
  localparam int FRAME_W        = 32;
  localparam int GAP_W          = 8;
  localparam int GAIN_W         = 16;
  localparam int ACTION_W       = 2;
  localparam int INC_W          = 40;
  localparam int NUM_W          = 44;
  localparam int DIV_W          = NUM_W;
  localparam int DIV_RADIX_BITS = 4;
  localparam int ADDR_W         = 5;
  localparam int REG_IDX_W      = 3;
  localparam int DATA_W         = 32;

  localparam logic [ACTION_W-1:0] ACT_REPORT  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_QUERY   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_RESTART = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_NOMINAL_PERIOD    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_RESYNC_WINDOW     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_MAX_PERIOD_ADJUST = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_MAX_FRAME_GAP     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_ESTIMATE_GAIN     = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_CORRECTION_GAIN   = 3'd5;

  localparam logic [PERIOD_W-1:0] NOMINAL_PERIOD_RESET    = 32'd42949673;
  localparam logic [PERIOD_W-1:0] RESYNC_WINDOW_RESET     = 32'd858993459;
  localparam logic [PERIOD_W-1:0] MAX_PERIOD_ADJUST_RESET = 32'd4294967;
  localparam logic [GAP_W-1:0]    MAX_FRAME_GAP_RESET     = 8'd10;
  localparam logic [GAIN_W-1:0]   ESTIMATE_GAIN_RESET     = 16'd655;
  localparam logic [GAIN_W-1:0]   CORRECTION_GAIN_RESET   = 16'd6554;

  typedef struct packed {
    logic [PERIOD_W-1:0] nominal_period;
    logic [PERIOD_W-1:0] resync_window;
    logic [PERIOD_W-1:0] max_period_adjust;
    logic [GAP_W-1:0]    max_frame_gap;
    logic [GAIN_W-1:0]   estimate_gain;
    logic [GAIN_W-1:0]   correction_gain;
  } ftr_cfg_t;

  typedef struct packed {
    logic load;
    logic restart;
    logic take_frame;
    logic resync;
    logic mul_pred;
    logic add_pred;
    logic err_calc;
    logic num_calc;
    logic div_start;
    logic delta_calc;
    logic gain_mul;
    logic upd_est;
    logic upd_next;
    logic q_mul;
    logic q_add;
  } ftr_cmd_t;

  typedef struct packed {
    logic stale;
    logic gap_big;
    logic err_big;
    logic div_done;
  } ftr_stat_t;

  typedef struct packed {
    logic emit;
    logic accepted;
    logic resynced;
    logic query;
  } ftr_res_t;

endpackage

### rtl/ftr_div.sv
// Iterative unsigned divider, four quotient bits per cycle.
`include "frame_timestamp_recovery_assert.svh"

module ftr_div import ftr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [GAP_W-1:0] divisor,
  output logic [DIV_W-1:0] quotient,
  output logic             done
);

  localparam int DIV_CYCLES = DIV_W / DIV_RADIX_BITS;
  localparam int CNT_W      = $clog2(DIV_CYCLES + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [GAP_W-1:0] rem;
  logic [GAP_W-1:0] dsr;
  logic [GAP_W-1:0] rem_next;
  logic [DIV_W-1:0] quotient_next;
  logic [GAP_W:0]   trial;
  logic             take;

  always_comb begin
    rem_next      = rem;
    quotient_next = quotient;
    trial         = '0;
    take          = 1'b0;
    for (int i = 0; i < DIV_RADIX_BITS; i++) begin
      trial         = {rem_next, quotient_next[DIV_W-1]};
      take          = (trial >= {1'b0, dsr});
      quotient_next = {quotient_next[DIV_W-2:0], take};
      rem_next      = take ? GAP_W'(trial - {1'b0, dsr}) : trial[GAP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIV_CYCLES);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dsr      <= divisor;
    end else if (busy) begin
      quotient <= quotient_next;
      rem      <= rem_next;
    end
  end

  `FTR_ASSERT_NOW(a_div_start_idle, start, !busy, "divider started while busy")
  `FTR_ASSERT_NOW(a_div_done_at_end, $fell(busy), done, "divider ended without done")

endmodule

### rtl/ftr_dp.sv
// Datapath: timing state, prediction, error, gains and query extrapolation.
module ftr_dp import ftr_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  ftr_cmd_t            cmd,
  input  ftr_cfg_t            cfg,
  input  logic [FRAME_W-1:0]  frame_count,
  input  logic [TIME_W-1:0]   system_time,
  output ftr_stat_t           stat,
  output logic [TIME_W-1:0]   last_time,
  output logic [TIME_W-1:0]   query_time,
  output logic [PERIOD_W-1:0] est_period,
  output logic [PERIOD_W-1:0] next_period
);

  localparam int GE_W = NUM_W + GAIN_W;
  localparam int GC_W = PERIOD_W + GAIN_W;

  logic [FRAME_W-1:0]       last_frame;
  logic [FRAME_W-1:0]       frame_reg;
  logic [FRAME_W-1:0]       diff;
  logic [FRAME_W-1:0]       qmag;
  logic                     qback;
  logic                     stale;
  logic [TIME_W-1:0]        sys_reg;
  logic [TIME_W-1:0]        pred;
  logic [TIME_W-1:0]        err;
  logic [TIME_W-1:0]        qprod;
  logic [INC_W-1:0]         prod;
  logic [INC_W-1:0]         inc;
  logic                     err_neg;
  logic signed [NUM_W-1:0]  num;
  logic [NUM_W-1:0]         dmag;
  logic                     dneg;
  logic [NUM_W-1:0]         ge_mag;
  logic [PERIOD_W-1:0]      gc_mag;
  logic [PERIOD_W-1:0]      corr;

  logic [FRAME_W-1:0]       fwd_diff;
  logic [FRAME_W-1:0]       back_diff;
  logic [TIME_W:0]          pred_sum;
  logic [TIME_W:0]          qsum;
  logic [NUM_W-1:0]         err_ext;
  logic signed [NUM_W-1:0]  err_s;
  logic [NUM_W-1:0]         num_mag;
  logic [NUM_W-1:0]         quo;
  logic [NUM_W-1:0]         est_ext;
  logic [NUM_W-1:0]         q_plus_est;
  logic [GE_W-1:0]          ge_full;
  logic [GC_W-1:0]          gc_full;
  logic signed [NUM_W:0]    est_sum;
  logic signed [PERIOD_W+1:0] next_sum;
  logic [PERIOD_W-1:0]      est_clamped;
  logic [PERIOD_W-1:0]      next_clamped;
  logic [PERIOD_W-1:0]      corr_lim;
  logic                     div_done;

  assign fwd_diff   = frame_count - last_frame;
  assign back_diff  = last_frame - frame_count;
  assign pred_sum   = {1'b0, last_time} + {{(TIME_W + 1 - INC_W){1'b0}}, prod};
  assign qsum       = {1'b0, last_time} + {1'b0, qprod};
  assign err_ext    = {{(NUM_W - PERIOD_W){1'b0}}, err[PERIOD_W-1:0]};
  assign err_s      = err_neg ? -$signed(err_ext) : $signed(err_ext);
  assign num_mag    = num[NUM_W-1] ? $unsigned(-num) : $unsigned(num);
  assign est_ext    = {{(NUM_W - PERIOD_W){1'b0}}, est_period};
  assign q_plus_est = quo + est_ext;
  assign ge_full    = GE_W'(dmag) * GE_W'(cfg.estimate_gain);
  assign gc_full    = GC_W'(err[PERIOD_W-1:0]) * GC_W'(cfg.correction_gain);

  assign est_sum = $signed({1'b0, est_ext})
                 + (dneg ? -$signed({1'b0, ge_mag}) : $signed({1'b0, ge_mag}));
  assign est_clamped = est_sum[NUM_W] ? '0 :
                       (|est_sum[NUM_W-1:PERIOD_W]) ? '1 : est_sum[PERIOD_W-1:0];

  assign corr_lim = (gc_mag > cfg.max_period_adjust) ? cfg.max_period_adjust : gc_mag;

  assign next_sum = $signed({2'b0, est_period})
                  + (err_neg ? -$signed({2'b0, corr}) : $signed({2'b0, corr}));
  assign next_clamped = next_sum[PERIOD_W+1] ? '0 :
                        next_sum[PERIOD_W] ? '1 : next_sum[PERIOD_W-1:0];

  assign stat.stale    = stale;
  assign stat.gap_big  = (diff > FRAME_W'(cfg.max_frame_gap));
  assign stat.err_big  = (|err[TIME_W-1:PERIOD_W]) || (err[PERIOD_W-1:0] > cfg.resync_window);
  assign stat.div_done = div_done;

  ftr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (num_mag),
    .divisor  (diff[GAP_W-1:0]),
    .quotient (quo),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      last_time   <= '0;
      last_frame  <= '0;
      est_period  <= NOMINAL_PERIOD_RESET;
      next_period <= NOMINAL_PERIOD_RESET;
    end else begin
      if (cmd.restart) begin
        last_time   <= '0;
        last_frame  <= '0;
        est_period  <= cfg.nominal_period;
        next_period <= cfg.nominal_period;
      end
      if (cmd.take_frame) begin
        last_frame <= frame_reg;
      end
      if (cmd.resync) begin
        next_period <= est_period;
        last_time   <= sys_reg;
      end
      if (cmd.upd_est) begin
        est_period <= est_clamped;
      end
      if (cmd.upd_next) begin
        next_period <= next_clamped;
        last_time   <= pred;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      frame_reg <= frame_count;
      sys_reg   <= system_time;
      diff      <= fwd_diff;
      qback     <= fwd_diff[FRAME_W-1];
      qmag      <= fwd_diff[FRAME_W-1] ? back_diff : fwd_diff;
      stale     <= (frame_count <= last_frame);
    end
    if (cmd.mul_pred) begin
      prod <= INC_W'(diff[GAP_W-1:0]) * INC_W'(next_period);
    end
    if (cmd.add_pred) begin
      if (pred_sum[TIME_W]) begin
        pred <= '1;
        inc  <= INC_W'(~last_time);
      end else begin
        pred <= pred_sum[TIME_W-1:0];
        inc  <= prod;
      end
    end
    if (cmd.err_calc) begin
      err_neg <= (sys_reg < pred);
      err     <= (sys_reg < pred) ? pred - sys_reg : sys_reg - pred;
    end
    if (cmd.num_calc) begin
      num <= $signed({{(NUM_W - INC_W){1'b0}}, inc}) + err_s;
    end
    if (cmd.delta_calc) begin
      if (num[NUM_W-1]) begin
        dmag <= q_plus_est;
        dneg <= 1'b1;
      end else if (quo >= est_ext) begin
        dmag <= quo - est_ext;
        dneg <= 1'b0;
      end else begin
        dmag <= est_ext - quo;
        dneg <= 1'b1;
      end
    end
    if (cmd.gain_mul) begin
      ge_mag <= ge_full[GE_W-1:GAIN_W];
      gc_mag <= gc_full[GC_W-1:GAIN_W];
    end
    if (cmd.upd_est) begin
      corr <= corr_lim;
    end
    if (cmd.q_mul) begin
      qprod <= TIME_W'(qmag) * TIME_W'(est_period);
    end
    if (cmd.q_add) begin
      if (qback) begin
        query_time <= (qprod > last_time) ? '0 : last_time - qprod;
      end else begin
        query_time <= qsum[TIME_W] ? '1 : qsum[TIME_W-1:0];
      end
    end
  end

endmodule

### rtl/ftr_ctrl.sv
// Controller: sequences each transfer through the datapath steps.
`include "frame_timestamp_recovery_assert.svh"

module ftr_ctrl import ftr_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  logic [ACTION_W-1:0] action,
  input  ftr_stat_t           stat,
  input  logic                slot_free,
  output ftr_cmd_t            cmd,
  output ftr_res_t            res_ctl
);

  localparam int ST_W = 5;
  localparam logic [ST_W-1:0] ST_IDLE      = 5'd0;
  localparam logic [ST_W-1:0] ST_DISPATCH  = 5'd1;
  localparam logic [ST_W-1:0] ST_PRED_MUL  = 5'd2;
  localparam logic [ST_W-1:0] ST_PRED_ADD  = 5'd3;
  localparam logic [ST_W-1:0] ST_ERR_CALC  = 5'd4;
  localparam logic [ST_W-1:0] ST_ERR_CHECK = 5'd5;
  localparam logic [ST_W-1:0] ST_DIV_START = 5'd6;
  localparam logic [ST_W-1:0] ST_DIV_WAIT  = 5'd7;
  localparam logic [ST_W-1:0] ST_DELTA     = 5'd8;
  localparam logic [ST_W-1:0] ST_GAIN_MUL  = 5'd9;
  localparam logic [ST_W-1:0] ST_UPD_EST   = 5'd10;
  localparam logic [ST_W-1:0] ST_UPD_NEXT  = 5'd11;
  localparam logic [ST_W-1:0] ST_RESYNC    = 5'd12;
  localparam logic [ST_W-1:0] ST_QUERY_MUL = 5'd13;
  localparam logic [ST_W-1:0] ST_QUERY_ADD = 5'd14;
  localparam logic [ST_W-1:0] ST_FINISH    = 5'd15;

  logic [ST_W-1:0]     state;
  logic [ST_W-1:0]     state_next;
  logic [ACTION_W-1:0] act;
  logic                acc;
  logic                rs;
  logic                qry;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      act   <= ACT_REPORT;
      acc   <= 1'b0;
      rs    <= 1'b0;
      qry   <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        act <= action;
        acc <= 1'b0;
        rs  <= 1'b0;
        qry <= 1'b0;
      end
      if (cmd.take_frame) begin
        acc <= 1'b1;
      end
      if (cmd.resync) begin
        rs <= 1'b1;
      end
      if (cmd.q_mul) begin
        qry <= 1'b1;
      end
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (item_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        unique case (act)
          ACT_REPORT: begin
            if (stat.stale) begin
              state_next = ST_FINISH;
            end else begin
              cmd.take_frame = 1'b1;
              state_next     = stat.gap_big ? ST_RESYNC : ST_PRED_MUL;
            end
          end
          ACT_QUERY: begin
            state_next = ST_QUERY_MUL;
          end
          ACT_RESTART: begin
            cmd.restart = 1'b1;
            state_next  = ST_FINISH;
          end
          default: begin
            state_next = ST_FINISH;
          end
        endcase
      end
      ST_PRED_MUL: begin
        cmd.mul_pred = 1'b1;
        state_next   = ST_PRED_ADD;
      end
      ST_PRED_ADD: begin
        cmd.add_pred = 1'b1;
        state_next   = ST_ERR_CALC;
      end
      ST_ERR_CALC: begin
        cmd.err_calc = 1'b1;
        state_next   = ST_ERR_CHECK;
      end
      ST_ERR_CHECK: begin
        cmd.num_calc = 1'b1;
        state_next   = stat.err_big ? ST_RESYNC : ST_DIV_START;
      end
      ST_DIV_START: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (stat.div_done) begin
          state_next = ST_DELTA;
        end
      end
      ST_DELTA: begin
        cmd.delta_calc = 1'b1;
        state_next     = ST_GAIN_MUL;
      end
      ST_GAIN_MUL: begin
        cmd.gain_mul = 1'b1;
        state_next   = ST_UPD_EST;
      end
      ST_UPD_EST: begin
        cmd.upd_est = 1'b1;
        state_next  = ST_UPD_NEXT;
      end
      ST_UPD_NEXT: begin
        cmd.upd_next = 1'b1;
        state_next   = ST_FINISH;
      end
      ST_RESYNC: begin
        cmd.resync = 1'b1;
        state_next = ST_FINISH;
      end
      ST_QUERY_MUL: begin
        cmd.q_mul  = 1'b1;
        state_next = ST_QUERY_ADD;
      end
      ST_QUERY_ADD: begin
        cmd.q_add  = 1'b1;
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign item_stall       = (state != ST_IDLE);
  assign res_ctl.emit     = (state == ST_FINISH) && slot_free;
  assign res_ctl.accepted = acc;
  assign res_ctl.resynced = rs;
  assign res_ctl.query    = qry;

  `FTR_ASSERT_NOW(a_resync_needs_accept, res_ctl.emit && res_ctl.resynced, res_ctl.accepted,
                  "resync reported without an accepted frame")

endmodule

### rtl/frame_timestamp_recovery.sv
// Top level of the frame timestamp recovery block: registers, control, datapath, output stage.
// Report: the radix-16 divide by the frame gap dominates; a resync on frame gap or on time
// error skips the divide. Query: one 32x32 multiply and one saturating add or subtract.
// One item in flight; the next is taken while a result waits.
// Reset (rst, synchronous): registers to defaults, last time and frame to zero, periods nominal.
`include "frame_timestamp_recovery_assert.svh"

module frame_timestamp_recovery import ftr_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready,
  input  logic                item_valid,
  output logic                item_stall,
  input  logic [ACTION_W-1:0] action,
  input  logic [FRAME_W-1:0]  frame_count,
  input  logic [TIME_W-1:0]   system_time,
  output logic                result_valid,
  input  logic                result_stall,
  output logic                accepted,
  output logic                resynced,
  output logic [TIME_W-1:0]   frame_time,
  output logic [PERIOD_W-1:0] period_estimate,
  output logic [PERIOD_W-1:0] period_next
);

  ftr_cfg_t               cfg;
  ftr_cmd_t               cmd;
  ftr_stat_t              stat;
  ftr_res_t               res_ctl;
  logic                   wr_en;
  logic                   slot_free;
  logic [REG_IDX_W-1:0]   reg_idx;
  logic [TIME_W-1:0]      last_time;
  logic [TIME_W-1:0]      query_time;
  logic [PERIOD_W-1:0]    est_period;
  logic [PERIOD_W-1:0]    next_period;

  assign pready    = 1'b1;
  assign wr_en     = psel && penable && pwrite && pready;
  assign reg_idx   = paddr[ADDR_W-1:2];
  assign slot_free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.nominal_period    <= NOMINAL_PERIOD_RESET;
      cfg.resync_window     <= RESYNC_WINDOW_RESET;
      cfg.max_period_adjust <= MAX_PERIOD_ADJUST_RESET;
      cfg.max_frame_gap     <= MAX_FRAME_GAP_RESET;
      cfg.estimate_gain     <= ESTIMATE_GAIN_RESET;
      cfg.correction_gain   <= CORRECTION_GAIN_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_NOMINAL_PERIOD:    cfg.nominal_period    <= pwdata;
        REG_RESYNC_WINDOW:     cfg.resync_window     <= pwdata;
        REG_MAX_PERIOD_ADJUST: cfg.max_period_adjust <= pwdata;
        REG_MAX_FRAME_GAP:     cfg.max_frame_gap     <= pwdata[GAP_W-1:0];
        REG_ESTIMATE_GAIN:     cfg.estimate_gain     <= pwdata[GAIN_W-1:0];
        REG_CORRECTION_GAIN:   cfg.correction_gain   <= pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_NOMINAL_PERIOD:    prdata = cfg.nominal_period;
      REG_RESYNC_WINDOW:     prdata = cfg.resync_window;
      REG_MAX_PERIOD_ADJUST: prdata = cfg.max_period_adjust;
      REG_MAX_FRAME_GAP:     prdata = DATA_W'(cfg.max_frame_gap);
      REG_ESTIMATE_GAIN:     prdata = DATA_W'(cfg.estimate_gain);
      REG_CORRECTION_GAIN:   prdata = DATA_W'(cfg.correction_gain);
      default:               prdata = '0;
    endcase
  end

  ftr_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .action     (action),
    .stat       (stat),
    .slot_free  (slot_free),
    .cmd        (cmd),
    .res_ctl    (res_ctl)
  );

  ftr_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .cfg         (cfg),
    .frame_count (frame_count),
    .system_time (system_time),
    .stat        (stat),
    .last_time   (last_time),
    .query_time  (query_time),
    .est_period  (est_period),
    .next_period (next_period)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_ctl.emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ctl.emit) begin
      accepted        <= res_ctl.accepted;
      resynced        <= res_ctl.resynced;
      frame_time      <= res_ctl.query ? query_time : last_time;
      period_estimate <= est_period;
      period_next     <= next_period;
    end
  end

  `FTR_ASSERT_NEXT(a_one_item_at_a_time, item_valid && !item_stall, item_stall,
                   "second transfer taken while an item is in progress")
  `FTR_ASSERT_NOW(a_result_from_emit, $rose(result_valid), $past(res_ctl.emit),
                  "result valid raised without a finished item")

endmodule
